>>> sv/bce_pkg.sv
// bce_pkg: shared types and constants for the binary contour extractor.
// No dependencies; imported by every module of the block.
package bce_pkg;

  localparam int ROW_W        = 64;
  localparam int IDX_W        = 6;
  localparam int CFG_W        = 7;
  localparam int APB_AW       = 3;
  localparam int APB_DW       = 32;
  localparam int DEF_MAX_ROWS = 64;
  localparam int DEF_MAX_COLS = 64;

  localparam logic [0:0] REG_HEIGHT = 1'b0;
  localparam logic [0:0] REG_WIDTH  = 1'b1;

  localparam logic [CFG_W-1:0] HEIGHT_RST = 7'd64;
  localparam logic [CFG_W-1:0] WIDTH_RST  = 7'd64;

  typedef logic [ROW_W-1:0] row_t;

  typedef struct packed {
    logic [CFG_W-1:0] height;
    logic [CFG_W-1:0] width;
    logic             restart;
  } cfg_t;

endpackage

>>> sv/binary_contour_extract_top.sv
// binary_contour_extract_top: frame loader and row-by-row contour sequencer.
// Depends on bce_pkg, bce_cfg_regs, bce_frame_mem and bce_edge_unit.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+--------------------------------------
//   in_      | in_valid / in_ready   | in_row_pixels[63:0]
//   out_     | out_valid / out_ready | out_row_index, out_contour_row, out_last_row
//   cfg (APB)| psel/penable/pready   | paddr[2:0], pwdata, prdata
//
// A row request that does not close the frame is taken and in_ready stays high.
// The closing row starts emission: each output row passes memory read, edge unit
// and output register, and waits in the output register while out_ready is held low.
// in_ready drops with the closing row and returns once the last contour row is taken.
// rst_n is synchronous; the frame store is not cleared and needs no sweep.
module binary_contour_extract_top #(
  parameter int MAX_ROWS = bce_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = bce_pkg::DEF_MAX_COLS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [bce_pkg::ROW_W-1:0]   in_row_pixels,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [bce_pkg::IDX_W-1:0]   out_row_index,
  output logic [bce_pkg::ROW_W-1:0]   out_contour_row,
  output logic                        out_last_row,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bce_pkg::APB_AW-1:0]  paddr,
  input  logic [bce_pkg::APB_DW-1:0]  pwdata,
  output logic [bce_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);
  import bce_pkg::*;

  localparam int ROW_LIMIT = (MAX_ROWS < 64) ? MAX_ROWS : 64;
  localparam int AW        = (ROW_LIMIT > 1) ? $clog2(ROW_LIMIT) : 1;
  localparam int CNT_W     = $clog2(ROW_LIMIT + 1);

  typedef enum logic [1:0] {
    S_LOAD,
    S_FETCH,
    S_CALC,
    S_SEND
  } state_t;

  state_t           state_r;
  cfg_t             cfg;
  logic [CNT_W-1:0] h_act;
  logic [CFG_W-1:0] w_act;
  row_t             mask;
  row_t             masked_in;
  logic [AW-1:0]    cnt_r;
  logic [AW-1:0]    k_r;
  logic [CNT_W-1:0] cnt_inc;
  logic [CNT_W-1:0] k_inc;
  logic             load_last;
  logic             k_last;
  logic             in_acc;
  logic             rd_en;
  row_t             rd_data;
  row_t             row0_r;
  row_t             up_r;
  row_t             cur_r;
  row_t             nxt_r;
  row_t             dn;
  row_t             edge_q;
  logic [IDX_W-1:0] out_row_index_r;
  row_t             out_contour_row_r;
  logic             out_last_row_r;
  logic             out_valid_r;

  bce_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  always_comb begin
    if (cfg.height == '0) begin
      h_act = CNT_W'(1);
    end else if (cfg.height > CFG_W'(ROW_LIMIT)) begin
      h_act = CNT_W'(ROW_LIMIT);
    end else begin
      h_act = CNT_W'(cfg.height);
    end
    if (cfg.width == '0) begin
      w_act = CFG_W'(1);
    end else if (cfg.width > CFG_W'(MAX_COLS)) begin
      w_act = CFG_W'(MAX_COLS);
    end else begin
      w_act = cfg.width;
    end
  end

  assign mask      = (w_act >= CFG_W'(ROW_W)) ? '1 : ((ROW_W'(1) << w_act) - ROW_W'(1));
  assign masked_in = in_row_pixels & mask;

  assign cnt_inc   = CNT_W'(cnt_r) + CNT_W'(1);
  assign k_inc     = CNT_W'(k_r) + CNT_W'(1);
  assign load_last = (cnt_inc == h_act);
  assign k_last    = (k_inc == h_act);

  assign in_ready  = (state_r == S_LOAD);
  assign in_acc    = in_valid & in_ready;
  assign rd_en     = (state_r == S_FETCH) && !k_last;

  bce_frame_mem #(
    .DEPTH (ROW_LIMIT),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (in_acc),
    .waddr (cnt_r),
    .wdata (masked_in),
    .re    (rd_en),
    .raddr (AW'(k_inc)),
    .rdata (rd_data)
  );

  assign dn = k_last ? row0_r : rd_data;

  bce_edge_unit u_edge (
    .cur     (cur_r),
    .up      (up_r),
    .dn      (dn),
    .width   (w_act),
    .mask    (mask),
    .contour (edge_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_r       <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_LOAD: begin
          if (cfg.restart) begin
            cnt_r <= '0;
          end else if (in_acc) begin
            if (cnt_r == '0) begin
              row0_r <= masked_in;
            end
            if (load_last) begin
              up_r    <= masked_in;
              cur_r   <= (cnt_r == '0) ? masked_in : row0_r;
              k_r     <= '0;
              cnt_r   <= '0;
              state_r <= S_FETCH;
            end else begin
              cnt_r <= AW'(cnt_inc);
            end
          end
        end
        S_FETCH: begin
          state_r <= S_CALC;
        end
        S_CALC: begin
          out_contour_row_r <= edge_q;
          out_row_index_r   <= IDX_W'(k_r);
          out_last_row_r    <= k_last;
          nxt_r             <= dn;
          out_valid_r       <= 1'b1;
          state_r           <= S_SEND;
        end
        S_SEND: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            up_r        <= cur_r;
            cur_r       <= nxt_r;
            if (out_last_row_r) begin
              state_r <= S_LOAD;
            end else begin
              k_r     <= AW'(k_inc);
              state_r <= S_FETCH;
            end
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_row_index   = out_row_index_r;
  assign out_contour_row = out_contour_row_r;
  assign out_last_row    = out_last_row_r;

endmodule

>>> sv/bce_cfg_regs.sv
// bce_cfg_regs: APB register file holding frame height and width.
// Depends on bce_pkg; a write pulse restarts a frame that is still being loaded.
module bce_cfg_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bce_pkg::APB_AW-1:0] paddr,
  input  logic [bce_pkg::APB_DW-1:0] pwdata,
  output logic [bce_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  output bce_pkg::cfg_t              cfg
);
  import bce_pkg::*;

  logic [CFG_W-1:0] height_r;
  logic [CFG_W-1:0] width_r;
  logic             wr_en;

  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      height_r <= HEIGHT_RST;
      width_r  <= WIDTH_RST;
    end else if (wr_en) begin
      case (paddr[2])
        REG_HEIGHT: height_r <= pwdata[CFG_W-1:0];
        REG_WIDTH:  width_r  <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_HEIGHT: prdata = APB_DW'(height_r);
      REG_WIDTH:  prdata = APB_DW'(width_r);
      default:    prdata = '0;
    endcase
  end

  assign cfg.height  = height_r;
  assign cfg.width   = width_r;
  assign cfg.restart = wr_en;

endmodule

>>> sv/bce_frame_mem.sv
// bce_frame_mem: single-port-write, single-port-read frame store, registered read.
// Depends on bce_pkg for the row type.
module bce_frame_mem #(
  parameter int DEPTH = bce_pkg::DEF_MAX_ROWS,
  parameter int AW    = 6
) (
  input  logic           clk,
  input  logic           we,
  input  logic [AW-1:0]  waddr,
  input  bce_pkg::row_t  wdata,
  input  logic           re,
  input  logic [AW-1:0]  raddr,
  output bce_pkg::row_t  rdata
);
  import bce_pkg::*;

  row_t mem [DEPTH];
  row_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> sv/bce_edge_unit.sv
// bce_edge_unit: 4-neighbour contour of one row with toroidal wrap in width.
// Depends on bce_pkg; shared by every row of the frame.
module bce_edge_unit (
  input  bce_pkg::row_t                cur,
  input  bce_pkg::row_t                up,
  input  bce_pkg::row_t                dn,
  input  logic [bce_pkg::CFG_W-1:0]    width,
  input  bce_pkg::row_t                mask,
  output bce_pkg::row_t                contour
);
  import bce_pkg::*;

  logic [IDX_W-1:0] wm1;
  row_t             right_nb;
  row_t             left_nb;
  row_t             inner;

  assign wm1      = IDX_W'(width - CFG_W'(1));
  assign right_nb = (cur >> 1) | (ROW_W'(cur[0]) << wm1);
  assign left_nb  = ((cur << 1) & mask) | ROW_W'(cur[wm1]);
  assign inner    = left_nb & right_nb & up & dn;
  assign contour  = cur & ~inner & mask;

endmodule

>>> sim/bce_checker.sv
// bce_checker: passive checker for the contour extractor. It follows row requests
// and register writes, predicts every contour row and compares the results field by field.
// Depends on bce_pkg.
`timescale 1ns / 100ps

module bce_checker #(
  parameter int MAX_ROWS = bce_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = bce_pkg::DEF_MAX_COLS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [bce_pkg::ROW_W-1:0]  in_row_pixels,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [bce_pkg::IDX_W-1:0]  out_row_index,
  input  logic [bce_pkg::ROW_W-1:0]  out_contour_row,
  input  logic                       out_last_row,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bce_pkg::APB_AW-1:0] paddr,
  input  logic [bce_pkg::APB_DW-1:0] pwdata,
  input  logic                       pready,
  output int                         fail_count,
  output int                         pending,
  output int                         contours_seen
);
  import bce_pkg::*;

  localparam int ROW_LIMIT = (MAX_ROWS < 64) ? MAX_ROWS : 64;
  localparam int COL_LIMIT = (MAX_COLS < 64) ? MAX_COLS : 64;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    row_t             mask;
    logic             last;
  } contour_t;

  contour_t         contour_q[$];
  row_t             frame_rows[ROW_LIMIT];
  logic [CFG_W-1:0] height_reg;
  logic [CFG_W-1:0] width_reg;
  int               rows_held;

  function automatic int clamp_span(input logic [CFG_W-1:0] v, input int top);
    int n;
    n = int'(v);
    if (n < 1) n = 1;
    if (n > top) n = top;
    return n;
  endfunction

  // neighbours wrap round within the active width
  function automatic row_t ring_contour(input row_t r, input row_t u, input row_t d,
                                        input int w, input row_t m);
    row_t right_nb;
    row_t left_nb;
    right_nb = (r >> 1) | ((r & row_t'(1)) << (w - 1));
    left_nb  = ((r << 1) & m) | ((r >> (w - 1)) & row_t'(1));
    return r & ~(left_nb & right_nb & u & d) & m;
  endfunction

  task automatic report_mismatch(input string what, input row_t got, input row_t want);
    fail_count++;
    $display("%0t mismatch: %s got %h expected %h", $time, what, got, want);
  endtask

  task automatic take_row(input row_t px);
    int       h;
    int       w;
    int       k;
    int       up;
    int       dn;
    row_t     m;
    contour_t c;
    h = clamp_span(height_reg, ROW_LIMIT);
    w = clamp_span(width_reg, COL_LIMIT);
    m = (w >= 64) ? '1 : ((row_t'(1) << w) - row_t'(1));
    if (rows_held >= h) rows_held = 0;
    frame_rows[rows_held] = px & m;
    rows_held++;
    if (rows_held == h) begin
      for (k = 0; k < h; k++) begin
        up      = (k == 0) ? h - 1 : k - 1;
        dn      = (k + 1 == h) ? 0 : k + 1;
        c.index = IDX_W'(k);
        c.mask  = ring_contour(frame_rows[k], frame_rows[up], frame_rows[dn], w, m);
        c.last  = (k + 1 == h);
        contour_q.push_back(c);
      end
      rows_held = 0;
    end
  endtask

  task automatic check_contour();
    contour_t want;
    contours_seen++;
    if (contour_q.size() == 0) begin
      report_mismatch("contour row with nothing expected", out_contour_row, '0);
    end else begin
      want = contour_q.pop_front();
      if (out_row_index !== want.index)
        report_mismatch("row index", row_t'(out_row_index), row_t'(want.index));
      if (out_contour_row !== want.mask)
        report_mismatch("contour mask", out_contour_row, want.mask);
      if (out_last_row !== want.last)
        report_mismatch("last row flag", row_t'(out_last_row), row_t'(want.last));
    end
  endtask

  initial begin
    fail_count    = 0;
    contours_seen = 0;
    pending       = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      contour_q.delete();
      rows_held  = 0;
      height_reg = HEIGHT_RST;
      width_reg  = WIDTH_RST;
    end else begin
      if (out_valid && out_ready) check_contour();
      // any register write drops the partly loaded frame
      if (psel && penable && pwrite && pready) begin
        if (paddr[APB_AW-1:2] == REG_HEIGHT) begin
          height_reg = pwdata[CFG_W-1:0];
          rows_held  = 0;
        end else if (paddr[APB_AW-1:2] == REG_WIDTH) begin
          width_reg = pwdata[CFG_W-1:0];
          rows_held = 0;
        end
      end
      if (in_valid && in_ready) take_row(in_row_pixels);
    end
    pending <= contour_q.size();
  end

endmodule

>>> sim/binary_contour_extract_top_tb.sv
// binary_contour_extract_top_tb: drives row requests and register writes into the
// contour extractor, stalls the result side at random and gives the verdict.
// Depends on bce_pkg, binary_contour_extract_top and bce_checker.
`timescale 1ns / 100ps

module binary_contour_extract_top_tb;
  import bce_pkg::*;

  localparam int MAX_ROWS   = DEF_MAX_ROWS;
  localparam int MAX_COLS   = DEF_MAX_COLS;
  localparam int ROW_TARGET = 270;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  row_t              in_row_pixels;
  logic              out_valid;
  logic              out_ready;
  logic [IDX_W-1:0]  out_row_index;
  row_t              out_contour_row;
  logic              out_last_row;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  int fail_count;
  int pending;
  int contours_seen;
  int rows_sent     = 0;
  int settings_used = 0;
  int ready_wait    = 0;
  bit tx_fast       = 1'b0;
  bit rx_fast       = 1'b0;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  binary_contour_extract_top #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_row_pixels  (in_row_pixels),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_row_index  (out_row_index),
    .out_contour_row(out_contour_row),
    .out_last_row   (out_last_row),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  bce_checker #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_row_pixels  (in_row_pixels),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_row_index  (out_row_index),
    .out_contour_row(out_contour_row),
    .out_last_row   (out_last_row),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pready         (pready),
    .fail_count     (fail_count),
    .pending        (pending),
    .contours_seen  (contours_seen)
  );

  initial begin
    #2_000_000;
    $display("[binary_contour_extract_top] ERROR");
    $finish;
  end

  // result side: fresh stall drawn after every contour row taken
  initial begin : result_sink
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) ready_wait = rx_fast ? 0 : $urandom_range(0, 15);
      @(negedge clk);
      if (ready_wait > 0) begin
        out_ready <= 1'b0;
        ready_wait--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // valid is left high on return; the next call either reloads it or drops it
  task automatic send_row(input row_t px);
    int gap;
    gap = tx_fast ? 0 : $urandom_range(0, 15);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_row_pixels <= px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    rows_sent++;
  endtask

  task automatic hold_rows();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] which, input logic [CFG_W-1:0] val);
    logic [APB_DW-1:0] word;
    word             = $urandom();
    word[CFG_W-1:0]  = val;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'({which, 2'b00});
    pwdata  <= word;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_frame(input logic [CFG_W-1:0] h, input logic [CFG_W-1:0] w);
    hold_rows();
    wait_drained();
    write_reg(REG_HEIGHT, h);
    write_reg(REG_WIDTH, w);
    settings_used++;
  endtask

  function automatic int rows_per_frame(input logic [CFG_W-1:0] h);
    int lim;
    lim = (MAX_ROWS < 64) ? MAX_ROWS : 64;
    if (h == 0) return 1;
    return (int'(h) > lim) ? lim : int'(h);
  endfunction

  function automatic logic [CFG_W-1:0] pick_height();
    case ($urandom_range(0, 19))
      0:       return 7'd64;
      1:       return 7'd100;
      2, 3:    return 7'd1;
      4:       return 7'd0;
      default: return CFG_W'($urandom_range(2, 8));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_width();
    case ($urandom_range(0, 7))
      0:       return 7'd1;
      1:       return 7'd64;
      2:       return 7'd0;
      3:       return CFG_W'($urandom_range(65, 127));
      4, 5:    return CFG_W'($urandom_range(2, 16));
      default: return CFG_W'($urandom_range(1, 64));
    endcase
  endfunction

  function automatic row_t gen_row();
    case ($urandom_range(0, 7))
      0:       return '1;
      1:       return '0;
      2:       return {$urandom, $urandom} | {$urandom, $urandom} | {$urandom, $urandom};
      3:       return {$urandom, $urandom} & {$urandom, $urandom};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  initial begin : stimulus
    logic [CFG_W-1:0] h;
    logic [CFG_W-1:0] w;
    int               n_rows;
    int               n_frames;
    int               f;
    int               phase;
    bit               pressure_done;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_row_pixels = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    pressure_done = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    set_frame(7'd4, 7'd64);
    send_row('1);
    send_row('1);
    send_row(64'h8000_0000_0000_0001);
    send_row('0);

    // two rows then a write: the partial frame is thrown away
    set_frame(7'd3, 7'd8);
    send_row(64'hFFFF_FFFF_FFFF_FF00);
    send_row(64'h0000_0000_0000_003C);
    set_frame(7'd3, 7'd8);
    send_row('1);
    send_row(64'h0000_0000_0000_007E);
    send_row(64'h0000_0000_0000_0018);

    // zero height and width behave as one
    set_frame(7'd0, 7'd0);
    send_row(64'h0000_0000_0000_0001);
    send_row(64'hFFFF_FFFF_FFFF_FFFE);
    send_row('1);

    set_frame(7'd1, 7'd64);
    send_row('1);
    send_row(64'h0000_FFFF_0000_0001);

    set_frame(7'd2, 7'd127);
    send_row(64'hAAAA_AAAA_AAAA_AAAA);
    send_row(64'h5555_5555_5555_5555);

    set_frame(7'd5, 7'd63);
    send_row('1);
    send_row(64'hC000_0000_0000_0003);
    send_row('1);
    send_row(64'h4000_0000_0000_0001);
    send_row('0);

    phase = 0;
    while (rows_sent < ROW_TARGET) begin
      if (phase == 0) begin
        h = 7'd127;
        w = 7'd64;
      end else begin
        h = pick_height();
        w = pick_width();
      end
      set_frame(h, w);
      tx_fast  = ($urandom_range(0, 3) == 0);
      rx_fast  = ($urandom_range(0, 3) == 0);
      n_rows   = rows_per_frame(h);
      n_frames = (n_rows >= 32) ? 1 : $urandom_range(1, 3);
      for (f = 0; f < n_frames; f++) begin
        if (!pressure_done && f == 1) begin
          hold_rows();
          wait_drained();
          pressure_done = 1'b1;
        end
        repeat (n_rows) send_row(gen_row());
      end
      // now and then leave a partial frame for the next write to drop
      if (n_rows > 1 && $urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, n_rows - 1)) send_row(gen_row());
      phase++;
    end

    hold_rows();
    wait_drained();
    $display("Covered %0d row requests under %0d frame settings, %0d contour rows compared.",
             rows_sent, settings_used, contours_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("[binary_contour_extract_top] OK");
    end else begin
      $display("[binary_contour_extract_top] ERROR");
    end
    $finish;
  end

endmodule
